[rtl/ovl_pkg.sv]
// Shared types, codes and constants for the ordered value list.
package ovl_pkg;

    localparam int DEFAULT_LIST_DEPTH = 32;
    localparam int VALUE_W            = 32;
    localparam int ACTION_W           = 2;
    localparam int STATUS_W           = 2;
    localparam int COUNT_FIELD_W      = 6;

    // Request actions
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    // Broadcast controls for the row of cells
    typedef struct packed {
        logic cmp;     // capture match flag against the key
        logic load;    // write the key into the first free cell, whose index equals the count
        logic remove;  // close the gap: cells at or past the first match take the right value
        logic rotate;  // shift left by one, tail slot takes the head value
    } t_cell_ctl;

endpackage

[rtl/ordered_value_list_unit.sv]
// Ordered value list: a row of cells holding up to LIST_DEPTH 32-bit values in insertion order.
// Append: result follows in the next cycle; busy stays low, so a new request may follow at once.
// Remove and query: cells latch key-match flags; a first-match chain then lets remove close the gap.
// Read all: one result per entry (one per cycle), each cell rotating its value into its neighbor.
// Reset (synchronous, active low) empties the list; cell values are not cleared and need not be.
// Each result is shown for one cycle with o_strobe; the receiver cannot stall the block.
module ordered_value_list_unit
    import ovl_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [ACTION_W-1:0]      i_action,
    input  logic [VALUE_W-1:0]       i_value,
    output logic                     o_strobe,
    output logic [STATUS_W-1:0]      o_status,
    output logic [VALUE_W-1:0]       o_entry_value,
    output logic [COUNT_FIELD_W-1:0] o_entry_count,
    output logic                     o_last
);

    // Count holds 0..LIST_DEPTH inclusive.
    localparam int CW = $clog2(LIST_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_READ
    } t_state;

    t_state              r_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_left;
    logic [ACTION_W-1:0] r_action;

    t_cell_ctl           cell_ctl;
    logic                accept;
    logic                full;
    logic                found;
    logic [VALUE_W-1:0]  cell_value [LIST_DEPTH];
    logic                hit_chain  [LIST_DEPTH+1];

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign full   = (r_count >= CW'(LIST_DEPTH));
    // First-match chain ends here: any occupied cell matched the key.
    assign found  = hit_chain[LIST_DEPTH];

    // Broadcast controls to the cells
    always_comb begin
        cell_ctl        = '0;
        cell_ctl.load   = accept && (i_action == ACT_APPEND) && !full;
        cell_ctl.cmp    = accept && ((i_action == ACT_REMOVE) || (i_action == ACT_QUERY));
        cell_ctl.remove = (r_state == S_MATCH) && (r_action == ACT_REMOVE) && found;
        cell_ctl.rotate = (r_state == S_READ);
    end

    assign hit_chain[0] = 1'b0;

    // Row of cells; each hands its value to its left neighbor on remove and rotate (on rotate, head to tail).
    for (genvar g = 0; g < LIST_DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] right_value;

        if (g == LIST_DEPTH - 1) begin : g_end
            assign right_value = cell_value[0];
        end else begin : g_mid
            assign right_value = cell_value[g+1];
        end

        ovl_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (cell_ctl),
            .i_count       (r_count),
            .i_key         (i_value),
            .i_right_value (right_value),
            .i_head_value  (cell_value[0]),
            .i_hit         (hit_chain[g]),
            .o_value       (cell_value[g]),
            .o_hit         (hit_chain[g+1])
        );
    end

    // Sequencer: state, occupancy and the registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_left        <= '0;
            r_action      <= ACT_APPEND;
            o_strobe      <= 1'b0;
            o_status      <= ST_OK;
            o_entry_value <= '0;
            o_entry_count <= '0;
            o_last        <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_action <= i_action;
                        unique case (i_action) inside
                            ACT_APPEND: begin
                                // Drop the value when full; otherwise the free cell takes it.
                                o_strobe      <= 1'b1;
                                o_entry_value <= '0;
                                o_last        <= 1'b1;
                                if (full) begin
                                    o_status      <= ST_FULL;
                                    o_entry_count <= COUNT_FIELD_W'(r_count);
                                end else begin
                                    o_status      <= ST_OK;
                                    o_entry_count <= COUNT_FIELD_W'(r_count + CW'(1));
                                    r_count       <= r_count + CW'(1);
                                end
                            end
                            ACT_REMOVE, ACT_QUERY: begin
                                // Cells latch their match flags this cycle.
                                r_state <= S_MATCH;
                            end
                            ACT_READ: begin
                                if (r_count == '0) begin
                                    o_strobe      <= 1'b1;
                                    o_status      <= ST_MISSING;
                                    o_entry_value <= '0;
                                    o_entry_count <= '0;
                                    o_last        <= 1'b1;
                                end else begin
                                    r_left  <= r_count;
                                    r_state <= S_READ;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_MATCH: begin
                    o_strobe      <= 1'b1;
                    o_entry_value <= '0;
                    o_last        <= 1'b1;
                    r_state       <= S_IDLE;
                    if (!found) begin
                        o_status      <= ST_MISSING;
                        o_entry_count <= COUNT_FIELD_W'(r_count);
                    end else if (r_action == ACT_REMOVE) begin
                        // Cells from the first match onward advance; the count drops by one.
                        o_status      <= ST_OK;
                        o_entry_count <= COUNT_FIELD_W'(r_count - CW'(1));
                        r_count       <= r_count - CW'(1);
                    end else begin
                        o_status      <= ST_OK;
                        o_entry_count <= COUNT_FIELD_W'(r_count);
                    end
                end
                S_READ: begin
                    // Emit the head while the row rotates; once every entry has passed the head, the order is restored.
                    o_strobe      <= 1'b1;
                    o_status      <= ST_OK;
                    o_entry_value <= cell_value[0];
                    o_entry_count <= COUNT_FIELD_W'(r_count);
                    o_last        <= (r_left == CW'(1));
                    r_left        <= r_left - CW'(1);
                    if (r_left == CW'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(LIST_DEPTH))
        else $error("occupancy exceeds list depth");

    a_read_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_left != '0) && (r_left <= r_count))
        else $error("read-out counter out of range");

    a_search_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && ((i_action == ACT_REMOVE) || (i_action == ACT_QUERY))
        |=> (r_state == S_MATCH))
        else $error("search request did not enter match cycle");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_FULL)) |-> (o_entry_count == COUNT_FIELD_W'(LIST_DEPTH)))
        else $error("full status with list not full");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.remove |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not shrink the list");
`endif

endmodule

[rtl/ovl_cell.sv]
// One storage cell of the list row: value, match flag and neighbor shift.
module ovl_cell
    import ovl_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic [CW-1:0]      i_count,
    input  logic [VALUE_W-1:0] i_key,
    input  logic [VALUE_W-1:0] i_right_value,
    input  logic [VALUE_W-1:0] i_head_value,
    input  logic               i_hit,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_hit
);

    logic [VALUE_W-1:0] r_value;
    logic [VALUE_W-1:0] n_value;
    logic               r_match;
    logic               n_match;
    logic               occupied;
    logic               is_tail;
    logic               is_free_slot;

    assign occupied     = CW'(IDX) < i_count;
    assign is_tail      = CW'(IDX + 1) == i_count;
    assign is_free_slot = CW'(IDX) == i_count;

    assign o_value = r_value;
    assign o_hit   = i_hit | r_match;

    always_comb begin
        n_match = r_match;
        if (i_ctl.cmp) begin
            n_match = occupied && (r_value == i_key);
        end
    end

    always_comb begin
        n_value = r_value;
        if (i_ctl.load && is_free_slot) begin
            n_value = i_key;
        end else if (i_ctl.remove && o_hit) begin
            n_value = i_right_value;
        end else if (i_ctl.rotate) begin
            n_value = is_tail ? i_head_value : i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
        end else begin
            r_match <= n_match;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule
